FILE: rtl/svenc_pkg.sv
// ----------------------------------------------------------------------------
// svenc_pkg: shared types and constants of the signed varint encoder
// Width-select codes, item classification record and group constants.
// ----------------------------------------------------------------------------
package svenc_pkg;

	localparam int VALUE_W   = 64;
	localparam int PAD_W     = 6;
	localparam int WSEL_W    = 2;
	localparam int NAT_W     = 4;   // natural length 1..10
	localparam int MAX_NAT   = 10;
	localparam int GROUP_W   = 7;
	localparam int DEF_MAX_PAD = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [WSEL_W-1:0] WSEL_16    = 2'd0;
	localparam logic [WSEL_W-1:0] WSEL_32    = 2'd1;
	localparam logic [WSEL_W-1:0] WSEL_64    = 2'd2;

	localparam logic [GROUP_W-1:0] FILL_NEG = 7'h7F;
	localparam logic [GROUP_W-1:0] FILL_POS = 7'h00;

	// classified item, minus the parameter-sized byte total
	typedef struct packed {
		logic [VALUE_W-1:0] value;    // sign-extended to 64 bits
		logic [NAT_W-1:0]   nat_len;  // bytes of the plain encoding
	} cls_t;

endpackage

FILE: rtl/svenc_front.sv
// ----------------------------------------------------------------------------
// svenc_front: input classifier
// Sign-extends the value at the configured width, finds the natural
// encoding length and the final byte count after padding.
// ----------------------------------------------------------------------------
module svenc_front import svenc_pkg::*; #(
	parameter int MAX_PAD = DEF_MAX_PAD,
	localparam int TOT_MAX = (MAX_PAD > MAX_NAT) ? MAX_PAD : MAX_NAT,
	localparam int CNT_W = $clog2(TOT_MAX + 1)
) (
	input  logic [WSEL_W-1:0]  width_sel,
	input  logic [VALUE_W-1:0] value,
	input  logic [PAD_W-1:0]   pad_to,
	output cls_t               cls,
	output logic [CNT_W-1:0]   total
);

	localparam int CMP_W = (CNT_W > PAD_W) ? CNT_W : PAD_W;

	logic [VALUE_W-1:0] sext;
	logic [VALUE_W-1:0] diff;
	logic [NAT_W-1:0]   nat;
	logic [CMP_W-1:0]   pad_ext;
	logic [CMP_W-1:0]   pad_sat;
	logic [CMP_W-1:0]   nat_ext;

	always_comb begin
		case (width_sel)
			WSEL_16: sext = {{48{value[15]}}, value[15:0]};
			WSEL_32: sext = {{32{value[31]}}, value[31:0]};
			default: sext = value;
		endcase
	end

	// group k closes the encoding once every bit from 7k-1 upward is the sign
	assign diff = sext ^ {VALUE_W{sext[VALUE_W-1]}};

	always_comb begin
		nat = NAT_W'(MAX_NAT);
		for (int k = MAX_NAT - 1; k >= 1; k--) begin
			if ((diff >> (GROUP_W * k - 1)) == '0) begin
				nat = NAT_W'(k);
			end
		end
	end

	always_comb begin
		pad_ext = CMP_W'(pad_to);
		nat_ext = CMP_W'(nat);
		pad_sat = (pad_ext > CMP_W'(MAX_PAD)) ? CMP_W'(MAX_PAD) : pad_ext;
		total   = (pad_sat > nat_ext) ? CNT_W'(pad_sat) : CNT_W'(nat_ext);
	end

	assign cls.value   = sext;
	assign cls.nat_len = nat;

endmodule

FILE: rtl/svenc_queue.sv
// ----------------------------------------------------------------------------
// svenc_queue: short FIFO between classifier and serializer
// Flip-flop storage, one write and one read per cycle.
// ----------------------------------------------------------------------------
module svenc_queue import svenc_pkg::*; #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wr_data,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output logic [DATA_W-1:0] rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/svenc_back.sv
// ----------------------------------------------------------------------------
// svenc_back: byte serializer
// Shifts out 7-bit groups, then sign-fill bytes, one byte per cycle
// while out_stall is low, into a registered output beat.
// ----------------------------------------------------------------------------
module svenc_back import svenc_pkg::*; #(
	parameter int MAX_PAD = DEF_MAX_PAD,
	localparam int TOT_MAX = (MAX_PAD > MAX_NAT) ? MAX_PAD : MAX_NAT,
	localparam int CNT_W = $clog2(TOT_MAX + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  cls_t             q_cls,
	input  logic [CNT_W-1:0] q_total,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_byte,
	output logic             last
);

	logic               busy_q;
	logic [VALUE_W-1:0] shreg_q;
	logic               neg_q;
	logic [NAT_W-1:0]   nat_q;
	logic [CNT_W-1:0]   total_q;
	logic [CNT_W-1:0]   idx_q;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               last_q;

	logic               adv;
	logic               is_last;
	logic               in_groups;
	logic [GROUP_W-1:0] grp;
	logic               load;

	assign adv       = busy_q && (!out_valid_q || !out_stall);
	assign is_last   = ((idx_q + 1'b1) == total_q);
	assign in_groups = (idx_q < CNT_W'(nat_q));
	assign grp       = in_groups ? shreg_q[GROUP_W-1:0] : (neg_q ? FILL_NEG : FILL_POS);
	assign load      = q_valid && (!busy_q || (adv && is_last));
	assign q_pop     = load;

	always_ff @(posedge clk) begin
		if (load) begin
			shreg_q <= q_cls.value;
			neg_q   <= q_cls.value[VALUE_W-1];
			nat_q   <= q_cls.nat_len;
			total_q <= q_total;
		end else if (adv) begin
			shreg_q <= {{GROUP_W{neg_q}}, shreg_q[VALUE_W-1:GROUP_W]};
		end
		if (adv) begin
			out_byte_q <= {!is_last, grp};
			last_q     <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= busy_q;
			end
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (adv) begin
				if (is_last) begin
					busy_q <= 1'b0;
				end
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule

FILE: rtl/signed_varint_encoder_padded.sv
// ----------------------------------------------------------------------------
// signed_varint_encoder_padded: signed LEB128 encoder with minimum length
// Encodes one two's-complement value per input beat into a byte stream.
// ----------------------------------------------------------------------------
// Each input beat carries a value (used at 16, 32 or 64 bits per the
// width_select register written on the cfg port, reset 64 bits) and a
// minimum byte count pad_to, saturated to MAX_PAD. The encoder emits the
// signed LEB128 bytes of the value, least significant group first, with
// bit 7 set on all but the final byte; if the plain encoding is shorter
// than the minimum, sign-fill bytes (0xFF / 0x80) follow and a closing
// 0x7F / 0x00 ends it. last marks the final byte of each value. One
// output beat leaves per cycle while out_stall is low, so a value takes
// max(natural length, padded length) output bytes: 1 to 10 without
// padding, up to MAX_PAD with it; the serializer's shift register sets
// that rate, and queued values leave back to back with no gap. A
// two-entry queue between the classifier and the serializer lets input
// beats be taken while earlier values are still being sent. cfg_ready is
// always high; write the register only while the encoder is idle.
// ----------------------------------------------------------------------------
module signed_varint_encoder_padded import svenc_pkg::*; #(
	parameter int MAX_PAD = DEF_MAX_PAD
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [WSEL_W-1:0]         cfg_data,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [PAD_W-1:0]          pad_to,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                out_byte,
	output logic                      last
);

	localparam int TOT_MAX = (MAX_PAD > MAX_NAT) ? MAX_PAD : MAX_NAT;
	localparam int CNT_W   = $clog2(TOT_MAX + 1);
	localparam int ITEM_W  = $bits(cls_t) + CNT_W;

	logic [WSEL_W-1:0] width_sel_q;

	cls_t              f_cls;
	logic [CNT_W-1:0]  f_total;
	logic              q_full;
	logic              q_push;
	logic              q_pop;
	logic              q_not_empty;
	logic [ITEM_W-1:0] q_rd_data;
	cls_t              b_cls;
	logic [CNT_W-1:0]  b_total;

	// width register; a code of three behaves as 64 bits in the front end
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_sel_q <= WSEL_64;
		end else if (cfg_valid && cfg_ready) begin
			width_sel_q <= cfg_data;
		end
	end

	// front end: classify in the accept cycle, straight into the queue
	svenc_front #(
		.MAX_PAD (MAX_PAD)
	) u_front (
		.width_sel (width_sel_q),
		.value     (value),
		.pad_to    (pad_to),
		.cls       (f_cls),
		.total     (f_total)
	);

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	svenc_queue #(
		.DATA_W (ITEM_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_data   ({f_cls, f_total}),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_data   (q_rd_data)
	);

	assign b_cls   = q_rd_data[ITEM_W-1:CNT_W];
	assign b_total = q_rd_data[CNT_W-1:0];

	// back end: one byte per cycle unless the output stalls, registered output beat
	svenc_back #(
		.MAX_PAD (MAX_PAD)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.q_cls     (b_cls),
		.q_total   (b_total),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

FILE: tb/sv/tb_signed_varint_encoder_padded.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_varint_encoder_padded: self-checking bench for the padded encoder
// Drives values and minimum lengths under every width setting, predicts the
// signed LEB128 byte stream and checks each output beat in order.
// ----------------------------------------------------------------------------
module tb_signed_varint_encoder_padded import svenc_pkg::*; ();

	localparam int PAD_CAP     = DEF_MAX_PAD;
	localparam int CYCLE_LIMIT = 1_500_000;   // far above the slowest legal run
	localparam int TAIL_CYCLES = 64;          // quiet time after the last byte
	localparam int PHASE_ITEMS = 110;         // random items per width setting
	localparam int CALM_ITEMS  = 30;          // leading items of a phase with no idling

	// Select code 3 has no package name; the encoder treats it as 64 bits.
	localparam logic [WSEL_W-1:0] WSEL_SAT = 2'd3;

	// one predicted output beat
	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} enc_beat_t;

	logic                      clk        = 1'b0;
	logic                      arst_n     = 1'b0;
	logic                      cfg_valid  = 1'b0;
	logic                      cfg_ready;
	logic [WSEL_W-1:0]         cfg_data   = '0;
	logic                      in_valid   = 1'b0;
	logic                      in_stall;
	logic signed [VALUE_W-1:0] value      = '0;
	logic [PAD_W-1:0]          pad_to     = '0;
	logic                      out_valid;
	logic                      out_stall  = 1'b0;
	logic [7:0]                out_byte;
	logic                      last;

	enc_beat_t         expected_bytes[$];   // bytes still owed by the encoder, oldest first
	logic [WSEL_W-1:0] width_sel = WSEL_64; // bench copy of the width register
	bit                gaps_on   = 1'b0;    // random idling on both channels
	int                err_cnt   = 0;
	int                cycle_cnt = 0;

	signed_varint_encoder_padded #(
		.MAX_PAD(PAD_CAP)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.pad_to   (pad_to),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.last     (last)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake or a byte that never shows up ends here.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Idle lengths: mostly none, some short, a few long.
	// ------------------------------------------------------------------------
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 20);
	endfunction

	// Output back-pressure, changed on the falling edge only.
	always @(negedge clk) begin
		int hold_cnt;
		if (hold_cnt == 0 && gaps_on)
			hold_cnt = rand_gap();
		if (hold_cnt != 0) begin
			out_stall <= 1'b1;
			hold_cnt--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// Byte-stream prediction for one accepted value.
	// The value is cut to the configured width and sign-extended; 7-bit
	// groups go out low first until what remains is pure sign and the last
	// group's bit 6 agrees with it. Short encodings are then stretched with
	// sign-fill groups up to the (capped) minimum, continuation set on all
	// but the closing byte.
	// ------------------------------------------------------------------------
	function automatic void predict_leb128(input logic [63:0] raw, input logic [5:0] min_len);
		logic signed [63:0] rest;
		logic [6:0]         grp;
		logic               neg;
		logic               done;
		int                 pad;
		int                 count;
		enc_beat_t          b;
		case (width_sel)
			WSEL_16: rest = {{48{raw[15]}}, raw[15:0]};
			WSEL_32: rest = {{32{raw[31]}}, raw[31:0]};
			default: rest = raw;   // 64 bits, and code 3 saturates to it
		endcase
		neg   = rest[63];
		pad   = (min_len > PAD_CAP) ? PAD_CAP : int'(min_len);
		count = 0;
		done  = 1'b0;
		while (!done) begin
			grp   = rest[6:0];
			rest  = rest >>> 7;
			done  = (rest == {64{neg}}) && (grp[6] == neg);
			count++;
			b.data = {(!done || count < pad), grp};
			b.fin  = done && (count >= pad);
			expected_bytes.push_back(b);
		end
		// padding: fill groups, closing group drops the continuation bit
		while (count < pad) begin
			count++;
			b.data = {(count < pad), (neg ? FILL_NEG : FILL_POS)};
			b.fin  = (count == pad);
			expected_bytes.push_back(b);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Output checker: every accepted beat against the oldest prediction.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		enc_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				$error("out_byte: expected none, got %02h (last %0b)", out_byte, last);
				err_cnt++;
			end else begin
				want = expected_bytes.pop_front();
				if (out_byte !== want.data) begin
					$error("out_byte: expected %02h, got %02h", want.data, out_byte);
					err_cnt++;
				end
				if (last !== want.fin) begin
					$error("last: expected %0b, got %0b", want.fin, last);
					err_cnt++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Shared driving tasks. The sender returns just after the edge where its
	// beat was taken; valid stays high into the next beat when no gap is drawn.
	// ------------------------------------------------------------------------
	task automatic send_item(input logic [63:0] v, input logic [5:0] p);
		int gap;
		gap = gaps_on ? rand_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		value    <= v;
		pad_to   <= p;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		predict_leb128(v, p);
	endtask

	// Drop valid and hold off until every predicted byte has been seen.
	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	// Register writes happen only with the encoder empty.
	task automatic write_width(input logic [WSEL_W-1:0] sel);
		wait_drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= sel;
		do
			@(posedge clk);
		while (!cfg_ready);
		width_sel = sel;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random value: full range, powers of two and neighbors, small signed,
	// and sign runs of random length so every natural length shows up.
	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		byte         sb;
		int          k;
		case ($urandom_range(0, 3))
			0: v = {$urandom, $urandom};
			1: begin
				k = $urandom_range(0, 63);
				v = (64'd1 << k) + $urandom_range(0, 2) - 1;
				if ($urandom_range(0, 1))
					v = -v;
			end
			2: begin
				sb = byte'($urandom);
				v  = 64'(sb);
			end
			default: v = $signed({$urandom, $urandom}) >>> $urandom_range(0, 63);
		endcase
		return v;
	endfunction

	// Minimum length: mostly around the natural lengths, sometimes any
	// 6-bit value, sometimes near or above the cap.
	function automatic logic [5:0] rand_pad();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 6'($urandom_range(0, 12));
		else if (r < 9)
			return 6'($urandom_range(0, 63));
		else
			return 6'($urandom_range(28, 63));
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset width (64 bits): group and sign boundaries, both extremes.
	task automatic test_default_width();
		send_item(64'd0, 6'd0);
		send_item(-64'sd1, 6'd0);
		send_item(64'd63, 6'd0);     // largest one-byte positive
		send_item(-64'sd64, 6'd0);   // smallest one-byte negative
		send_item(64'd64, 6'd0);     // bit 6 set forces a second byte
		send_item(-64'sd65, 6'd0);
		send_item(64'h7FFF_FFFF_FFFF_FFFF, 6'd0);
		send_item(64'h8000_0000_0000_0000, 6'd0);
	endtask

	// Minimum length: equal to natural, above it, at the cap, and saturated.
	task automatic test_padding();
		send_item(64'd5, 6'd1);
		send_item(64'd5, 6'd3);
		send_item(-64'sd2, 6'd4);
		send_item(64'd200, 6'd2);    // minimum equals natural length
		send_item(64'h7FFF_FFFF_FFFF_FFFF, 6'd32);
		send_item(-64'sd1, 6'd63);   // capped at the maximum
		send_item(64'd0, 6'd33);
		send_item(-64'sd1, 6'd10);
	endtask

	// Narrow widths drop the upper bits; code 3 behaves as 64 bits.
	task automatic test_narrow_widths();
		write_width(WSEL_16);
		send_item(64'hDEAD_0000_0000_8000, 6'd0);
		send_item(64'h0123_4567_89AB_7FFF, 6'd5);
		write_width(WSEL_32);
		send_item(64'h1234_5678_8000_0000, 6'd0);
		send_item(64'hFFFF_FFFF_7FFF_FFFF, 6'd7);
		write_width(WSEL_SAT);
		send_item(64'h8000_0000_0000_0000, 6'd12);
		send_item(64'hFFFF_0000_0000_0000, 6'd0);
	endtask

	// Random traffic at one width: a calm stretch, then idling on both
	// sides, with one full drain halfway through.
	task automatic test_random_width(input logic [WSEL_W-1:0] sel);
		write_width(sel);
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			gaps_on = (i >= CALM_ITEMS);
			if (i == PHASE_ITEMS / 2)
				wait_drain();
			send_item(rand_value(), rand_pad());
		end
		gaps_on = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_width();
		test_padding();
		test_narrow_widths();
		test_random_width(WSEL_16);
		test_random_width(WSEL_32);
		test_random_width(WSEL_SAT);
		test_random_width(WSEL_64);

		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
